// ===== rtl/bstk_pkg.sv =====
package bstk_pkg;

  localparam int STACK_DEPTH = 8;
  localparam int PTR_W       = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

  localparam int OPCODE_W = 3;
  localparam int KIND_W   = 8;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;
  localparam int ECOUNT_W = 4;

  localparam logic [OPCODE_W-1:0] OP_PUSH  = 3'd0;
  localparam logic [OPCODE_W-1:0] OP_POP   = 3'd1;
  localparam logic [OPCODE_W-1:0] OP_CLEAR = 3'd2;
  localparam logic [OPCODE_W-1:0] OP_PEEK  = 3'd3;
  localparam logic [OPCODE_W-1:0] OP_SUM   = 3'd4;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic [OPCODE_W-1:0]       opcode;
    logic [KIND_W-1:0]         kind;
    logic signed [VALUE_W-1:0] value;
  } stk_in_t;

  typedef struct packed {
    logic [STATUS_W-1:0]       status;
    logic [KIND_W-1:0]         top_kind;
    logic signed [VALUE_W-1:0] top_value;
    logic signed [VALUE_W-1:0] kind_sum;
    logic [ECOUNT_W-1:0]       entry_count;
  } stk_out_t;

  typedef struct packed {
    logic [KIND_W-1:0]         kind;
    logic signed [VALUE_W-1:0] value;
  } entry_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DISPATCH,
    S_SUM_RUN,
    S_REPLY
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic rd_top;
    logic sum_step;
    logic reply;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_sum;
    logic sum_done;
  } dp_sts_t;

endpackage

// ===== rtl/bstk_ctrl.sv =====
module bstk_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  bstk_pkg::dp_sts_t sts,
  output bstk_pkg::dp_cmd_t cmd,
  output logic              busy
);
  import bstk_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (start) state_nxt = S_DISPATCH;
      end
      S_DISPATCH: begin
        state_nxt = sts.is_sum ? S_SUM_RUN : S_REPLY;
      end
      S_SUM_RUN: begin
        if (sts.sum_done) state_nxt = S_REPLY;
      end
      S_REPLY: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    case (state_r)
      S_IDLE: begin
        busy     = 1'b0;
        cmd.load = start;
      end
      S_DISPATCH: begin
        cmd.rd_top = 1'b1;
      end
      S_SUM_RUN: begin
        cmd.sum_step = 1'b1;
      end
      S_REPLY: begin
        cmd.reply = 1'b1;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  a_accept_dispatch: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> state_r == S_DISPATCH)
    else $error("accepted word did not enter dispatch");

endmodule

// ===== rtl/bstk_dp.sv =====
module bstk_dp (
  input  logic               clk,
  input  logic               rst_n,
  input  bstk_pkg::stk_in_t  in_data,
  input  bstk_pkg::dp_cmd_t  cmd,
  output bstk_pkg::dp_sts_t  sts,
  output bstk_pkg::stk_out_t out_data,
  output logic               out_valid
);
  import bstk_pkg::*;

  entry_t mem [STACK_DEPTH];

  stk_in_t                   item_r;
  entry_t                    rd_r;
  logic [CNT_W-1:0]          count_r;
  logic [CNT_W-1:0]          count_nxt;
  logic [CNT_W-1:0]          idx_r;
  logic                      pend_r;
  logic signed [VALUE_W-1:0] acc_r;
  stk_out_t                  out_r;
  stk_out_t                  out_nxt;
  logic                      out_valid_r;

  logic             full;
  logic             empty;
  logic             walk_done;
  logic [CNT_W-1:0] top_idx;
  logic [PTR_W-1:0] rd_addr;
  logic             rd_en;
  logic             wr_en;

  assign full      = (count_r == CNT_W'(STACK_DEPTH));
  assign empty     = (count_r == '0);
  assign walk_done = (idx_r == count_r);
  assign top_idx   = count_r - CNT_W'(1);
  assign rd_addr   = cmd.sum_step ? idx_r[PTR_W-1:0] : top_idx[PTR_W-1:0];
  assign rd_en     = cmd.rd_top || (cmd.sum_step && !walk_done);
  assign wr_en     = cmd.reply && (item_r.opcode == OP_PUSH) && !full;

  assign sts.is_sum   = (item_r.opcode == OP_SUM);
  assign sts.sum_done = walk_done && !pend_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[count_r[PTR_W-1:0]] <= '{kind: item_r.kind, value: item_r.value};
    end
    if (rd_en) begin
      rd_r <= mem[rd_addr];
    end
  end

  always_comb begin
    out_nxt             = '0;
    out_nxt.status      = ST_OK;
    count_nxt           = count_r;
    case (item_r.opcode)
      OP_PUSH: begin
        if (full) begin
          out_nxt.status = ST_FULL;
        end else begin
          count_nxt = count_r + CNT_W'(1);
        end
      end
      OP_POP, OP_PEEK: begin
        if (empty) begin
          out_nxt.status = ST_EMPTY;
        end else begin
          out_nxt.top_kind  = rd_r.kind;
          out_nxt.top_value = rd_r.value;
          if (item_r.opcode == OP_POP) count_nxt = top_idx;
        end
      end
      OP_CLEAR: begin
        count_nxt = '0;
      end
      OP_SUM: begin
        out_nxt.kind_sum = acc_r;
      end
      default: begin
        count_nxt = count_r;
      end
    endcase
    out_nxt.entry_count = ECOUNT_W'(count_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.reply;
      if (cmd.reply) count_r <= count_nxt;
      if (cmd.rd_top) begin
        pend_r <= 1'b0;
      end else if (cmd.sum_step) begin
        pend_r <= !walk_done;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) item_r <= in_data;
    if (cmd.reply) out_r <= out_nxt;
    if (cmd.rd_top) begin
      idx_r <= '0;
      acc_r <= '0;
    end else if (cmd.sum_step) begin
      if (!walk_done) idx_r <= idx_r + CNT_W'(1);
      // fold in the entry read last cycle
      if (pend_r && (rd_r.kind == item_r.kind)) acc_r <= acc_r + rd_r.value;
    end
  end

  assign out_data  = out_r;
  assign out_valid = out_valid_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(STACK_DEPTH))
    else $error("fill count above stack depth");

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |=> !out_valid_r)
    else $error("result strobe longer than one cycle");

  a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |=> count_r == $past(count_r) + CNT_W'(1))
    else $error("push did not advance fill count");

endmodule

// ===== rtl/bounded_stack_with_kind_sum.sv =====
// Bounded LIFO stack of kind/value entries with a per-kind sum.
// Input channel: drive in_data with start high; a word is taken at a rising
// edge where start is high and busy is low. busy stays high until the block
// can take the next word.
// Result channel: every input word yields one result word, shown on out_data
// for exactly one cycle with out_valid high. The receiver cannot stall; the
// result must be taken in that cycle.
// Push, pop, peek, clear and unused opcodes pass through the dispatch and
// reply states; the result strobe follows the reply state, and the next
// word can be taken at the edge that ends the strobe.
// Sum walks the stored entries through the single read port of the entry
// memory with one adder, so its run time grows with the number of stored
// entries, up to a full stack of 8.
// Reset (rst_n low, synchronous) empties the stack and drops any word in
// progress; entry contents are not cleared and need no clearing pass.
module bounded_stack_with_kind_sum (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  bstk_pkg::stk_in_t  in_data,
  output logic               out_valid,
  output bstk_pkg::stk_out_t out_data
);
  import bstk_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  bstk_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  bstk_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_data  (out_data),
    .out_valid (out_valid)
  );

endmodule
